// ----- sv/slfc_pkg.sv -----
// ----------------------------------------------------------------------------
// slfc_pkg
// Shared types and constants of the SLIP frame codec.
// ----------------------------------------------------------------------------
package slfc_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] REG_DIRECTION   = 3'd0;
    localparam logic [2:0] REG_EXTENDED    = 3'd1;
    localparam logic [2:0] REG_END_CODE    = 3'd2;
    localparam logic [2:0] REG_ESC_CODE    = 3'd3;
    localparam logic [2:0] REG_END_ESC     = 3'd4;
    localparam logic [2:0] REG_ESC_ESC     = 3'd5;
    localparam logic [2:0] REG_DC1_ESC     = 3'd6;
    localparam logic [2:0] REG_DC3_ESC     = 3'd7;

    // frame phase codes
    localparam logic [2:0] PH_ENC_START = 3'd0;
    localparam logic [2:0] PH_WAIT      = 3'd1;
    localparam logic [2:0] PH_NORMAL    = 3'd2;
    localparam logic [2:0] PH_ESCAPE    = 3'd3;
    localparam logic [2:0] PH_DONE      = 3'd4;

    localparam logic [7:0] DC1_BYTE = 8'h11;
    localparam logic [7:0] DC3_BYTE = 8'h13;

    // most result beats one input beat can cause
    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        logic       direction;
        logic       extended_set;
        logic [7:0] end_code;
        logic [7:0] escape_code;
        logic [7:0] end_escaped_code;
        logic [7:0] escape_escaped_code;
        logic [7:0] dc1_escaped_code;
        logic [7:0] dc3_escaped_code;
    } cfg_t;

    typedef struct packed {
        logic rearm;
        logic direction;
    } rearm_t;

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  out_byte;
        logic        frame_done;
        logic [15:0] byte_count;
        logic        last;
    } result_t;

endpackage

// ----- sv/slfc_cfg.sv -----
// ----------------------------------------------------------------------------
// slfc_cfg
// Configuration registers; flags a rearm when the direction is written.
// ----------------------------------------------------------------------------
module slfc_cfg
    import slfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    output cfg_t       cfg,
    output rearm_t     rearm
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_DIRECTION: cfg_next.direction           = cfg_data[0];
                REG_EXTENDED:  cfg_next.extended_set        = cfg_data[0];
                REG_END_CODE:  cfg_next.end_code            = cfg_data;
                REG_ESC_CODE:  cfg_next.escape_code         = cfg_data;
                REG_END_ESC:   cfg_next.end_escaped_code    = cfg_data;
                REG_ESC_ESC:   cfg_next.escape_escaped_code = cfg_data;
                REG_DC1_ESC:   cfg_next.dc1_escaped_code    = cfg_data;
                REG_DC3_ESC:   cfg_next.dc3_escaped_code    = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.direction           <= 1'b0;
            cfg_reg.extended_set        <= 1'b0;
            cfg_reg.end_code            <= 8'hC0;
            cfg_reg.escape_code         <= 8'hDB;
            cfg_reg.end_escaped_code    <= 8'hDC;
            cfg_reg.escape_escaped_code <= 8'hDD;
            cfg_reg.dc1_escaped_code    <= 8'hDE;
            cfg_reg.dc3_escaped_code    <= 8'hDF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg             = cfg_reg;
    assign rearm.rearm     = cfg_write && (cfg_index == REG_DIRECTION);
    assign rearm.direction = cfg_data[0];

endmodule

// ----- sv/slfc_core.sv -----
// ----------------------------------------------------------------------------
// slfc_core
// Input register, frame state and the single-pass encode/decode logic that
// turns one beat into up to three result beats.
// ----------------------------------------------------------------------------
module slfc_core
    import slfc_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  rearm_t     rearm,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       command,
    input  logic [7:0] data_byte,
    input  logic       can_load,
    output logic       load,
    output result_t    res [MAX_RESULTS],
    output logic [1:0] res_count
);

    localparam int EW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    logic                   in_vld_reg;
    logic                   cmd_reg;
    logic [7:0]             byte_reg;
    logic [2:0]             phase_reg;
    logic [2:0]             phase_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   fire;

    function automatic logic [COUNT_WIDTH-1:0] sat_add(
        input logic [COUNT_WIDTH-1:0] c,
        input logic [1:0]             inc
    );
        logic [COUNT_WIDTH:0] sum;
        sum = {1'b0, c} + (COUNT_WIDTH+1)'(inc);
        if (sum[COUNT_WIDTH])
            return {COUNT_WIDTH{1'b1}};
        return sum[COUNT_WIDTH-1:0];
    endfunction

    function automatic logic [15:0] report(input logic [COUNT_WIDTH-1:0] c);
        logic [EW-1:0] wide;
        wide = EW'(c);
        if (wide > EW'(16'hFFFF))
            return 16'hFFFF;
        return wide[15:0];
    endfunction

    assign fire     = in_vld_reg && can_load;
    assign in_ready = !in_vld_reg || can_load;
    assign load     = fire;

    always_comb
    begin
        logic [1:0] k;
        logic       start;
        logic       hit;
        logic [7:0] b;
        logic [7:0] prefix_free;
        logic       emit;

        k           = 2'd0;
        start       = 1'b0;
        hit         = 1'b0;
        b           = byte_reg;
        prefix_free = byte_reg;
        emit        = 1'b0;
        phase_next  = phase_reg;
        count_next  = count_reg;
        for (int i = 0; i < MAX_RESULTS; i++)
            res[i] = '0;

        if (cmd_reg)
        begin
            res[0].frame_done = 1'b1;
            res[0].last       = 1'b1;
            if (!cfg.direction)
            begin
                res[0].byte_valid = 1'b1;
                res[0].out_byte   = cfg.end_code;
                res[0].byte_count = report(sat_add(count_reg, 2'd1));
            end
            else
            begin
                res[0].byte_count = report(count_reg);
            end
            k          = 2'd1;
            phase_next = cfg.direction ? PH_WAIT : PH_ENC_START;
            count_next = '0;
        end
        else if (!cfg.direction)
        begin
            start = (phase_reg == PH_ENC_START);
            // escape table, first match wins
            if (byte_reg == cfg.end_code)
            begin
                hit = 1'b1;  prefix_free = cfg.end_escaped_code;
            end
            else if (byte_reg == cfg.escape_code)
            begin
                hit = 1'b1;  prefix_free = cfg.escape_escaped_code;
            end
            else if (cfg.extended_set && byte_reg == DC1_BYTE)
            begin
                hit = 1'b1;  prefix_free = cfg.dc1_escaped_code;
            end
            else if (cfg.extended_set && byte_reg == DC3_BYTE)
            begin
                hit = 1'b1;  prefix_free = cfg.dc3_escaped_code;
            end

            if (start)
            begin
                res[k].byte_valid = 1'b1;
                res[k].out_byte   = cfg.end_code;
                k                 = k + 2'd1;
                phase_next        = PH_NORMAL;
            end
            if (hit)
            begin
                res[k].byte_valid = 1'b1;
                res[k].out_byte   = cfg.escape_code;
                k                 = k + 2'd1;
            end
            res[k].byte_valid = 1'b1;
            res[k].out_byte   = prefix_free;
            res[k].last       = 1'b1;
            k                 = k + 2'd1;
            count_next = sat_add(start ? '0 : count_reg, k);
        end
        else
        begin
            case (phase_reg)
                PH_NORMAL:
                begin
                    if (byte_reg == cfg.end_code)
                    begin
                        // empty frames are dropped
                        if (count_reg != '0)
                            phase_next = PH_DONE;
                    end
                    else if (byte_reg == cfg.escape_code)
                        phase_next = PH_ESCAPE;
                    else
                        emit = 1'b1;
                end
                PH_ESCAPE:
                begin
                    emit = 1'b1;
                    // unknown code passes through and the escape phase stays
                    if (byte_reg == cfg.end_escaped_code)
                    begin
                        b = cfg.end_code;     phase_next = PH_NORMAL;
                    end
                    else if (byte_reg == cfg.escape_escaped_code)
                    begin
                        b = cfg.escape_code;  phase_next = PH_NORMAL;
                    end
                    else if (cfg.extended_set && byte_reg == cfg.dc1_escaped_code)
                    begin
                        b = DC1_BYTE;         phase_next = PH_NORMAL;
                    end
                    else if (cfg.extended_set && byte_reg == cfg.dc3_escaped_code)
                    begin
                        b = DC3_BYTE;         phase_next = PH_NORMAL;
                    end
                end
                PH_WAIT, PH_ENC_START:
                begin
                    if (byte_reg == cfg.end_code)
                    begin
                        phase_next = PH_NORMAL;
                        count_next = '0;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
            if (emit)
            begin
                res[0].byte_valid = 1'b1;
                res[0].out_byte   = b;
                res[0].last       = 1'b1;
                k                 = 2'd1;
                count_next        = sat_add(count_reg, 2'd1);
            end
        end
        res_count = k;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            phase_reg  <= PH_ENC_START;
            count_reg  <= '0;
        end
        else
        begin
            if (in_ready)
                in_vld_reg <= in_valid;
            if (rearm.rearm)
            begin
                phase_reg <= rearm.direction ? PH_WAIT : PH_ENC_START;
                count_reg <= '0;
            end
            else if (fire)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg  <= command;
            byte_reg <= data_byte;
        end
    end

endmodule

// ----- sv/slfc_queue.sv -----
// ----------------------------------------------------------------------------
// slfc_queue
// Result register: holds the beats of one item and hands them out in order.
// ----------------------------------------------------------------------------
module slfc_queue
    import slfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  result_t     res [MAX_RESULTS],
    input  logic [1:0]  res_count,
    output logic        can_load,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        byte_valid,
    output logic [7:0]  out_byte,
    output logic        frame_done,
    output logic [15:0] byte_count,
    output logic        last
);

    result_t    slot_reg [MAX_RESULTS];
    logic [1:0] cnt_reg;
    logic       pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    // a new item may land once the head beat is the last one and leaves now
    assign can_load  = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else if (load)
            cnt_reg <= res_count;
        else if (pop)
            cnt_reg <= cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
                slot_reg[i] <= res[i];
        end
        else if (pop)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
                slot_reg[i] <= slot_reg[i+1];
        end
    end

    assign byte_valid = slot_reg[0].byte_valid;
    assign out_byte   = slot_reg[0].out_byte;
    assign frame_done = slot_reg[0].frame_done;
    assign byte_count = slot_reg[0].byte_count;
    assign last       = slot_reg[0].last;

endmodule

// ----- sv/slip_frame_codec.sv -----
// ----------------------------------------------------------------------------
// slip_frame_codec
// SLIP framer and deframer, one data byte or end command per input beat.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): command and data_byte. Output channel
// (out_valid/out_ready): one result beat each, last marks the final beat
// caused by an input beat. An input beat causes zero to three result beats.
// A beat is registered in the input register, then processed combinationally
// into the result register once it can take it, which drives the outputs.
// Throughput: one input beat per cycle while it causes at most one result
// and the receiver is ready; otherwise input waits while the single output
// register drains its beats one per cycle (escaped bytes in encode cause two
// beats, the first byte of a frame with an escape three). A stalled receiver
// holds the current result beat; one further input beat is taken into the
// input register and waits there. Reset clears both channels, loads the
// default codes and arms encode mode with an empty frame count. Configuration
// writes take effect at once and are to be made by the user only while the
// block is idle (not enforced); writing the direction rearms it.
// ----------------------------------------------------------------------------
module slip_frame_codec
    import slfc_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        byte_valid,
    output logic [7:0]  out_byte,
    output logic        frame_done,
    output logic [15:0] byte_count,
    output logic        last
);

    cfg_t       cfg;
    rearm_t     rearm;
    logic       can_load;
    logic       load;
    result_t    res [MAX_RESULTS];
    logic [1:0] res_count;

    slfc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .rearm     (rearm)
    );

    slfc_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .rearm     (rearm),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .data_byte (data_byte),
        .can_load  (can_load),
        .load      (load),
        .res       (res),
        .res_count (res_count)
    );

    slfc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .res        (res),
        .res_count  (res_count),
        .can_load   (can_load),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .byte_valid (byte_valid),
        .out_byte   (out_byte),
        .frame_done (frame_done),
        .byte_count (byte_count),
        .last       (last)
    );

endmodule

// ----- bench/slip_frame_codec_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slip_frame_codec_tb
// Self-checking bench for the SLIP frame codec. A scoreboard class predicts
// the result beats of every accepted input beat from its own copy of the
// codes and frame state, and compares each accepted result beat field by
// field. Directed frames cover escaping, stray and empty frames and unknown
// escapes; random phases then vary every register.
// ----------------------------------------------------------------------------
module slip_frame_codec_tb;
    import slfc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 10;
    localparam int RANDOM_ITEMS   = 140;
    localparam int PHASE_ITEMS    = 25;
    localparam int BURST_ITEMS    = 40;

    class codec_scoreboard;
        cfg_t        regs;
        logic [2:0]  phase;
        logic [15:0] frame_bytes;
        result_t     expected_q[$];
        int          failures;

        function new();
            regs.direction           = 1'b0;
            regs.extended_set        = 1'b0;
            regs.end_code            = 8'hC0;
            regs.escape_code         = 8'hDB;
            regs.end_escaped_code    = 8'hDC;
            regs.escape_escaped_code = 8'hDD;
            regs.dc1_escaped_code    = 8'hDE;
            regs.dc3_escaped_code    = 8'hDF;
            failures = 0;
            rearm();
        endfunction

        function void rearm();
            phase       = regs.direction ? PH_WAIT : PH_ENC_START;
            frame_bytes = '0;
        endfunction

        function void count_up();
            if (frame_bytes != 16'hFFFF)
                frame_bytes++;
        endfunction

        function logic [7:0] raw_code(int i);
            case (i)
                0:       return regs.end_code;
                1:       return regs.escape_code;
                2:       return DC1_BYTE;
                default: return DC3_BYTE;
            endcase
        endfunction

        function logic [7:0] escaped_code(int i);
            case (i)
                0:       return regs.end_escaped_code;
                1:       return regs.escape_escaped_code;
                2:       return regs.dc1_escaped_code;
                default: return regs.dc3_escaped_code;
            endcase
        endfunction

        function void add_beat(logic bv, logic [7:0] b, logic fd, logic [15:0] cnt);
            result_t r;
            r.byte_valid = bv;
            r.out_byte   = b;
            r.frame_done = fd;
            r.byte_count = cnt;
            r.last       = 1'b0;
            expected_q.push_back(r);
        endfunction

        function void write_reg(logic [2:0] idx, logic [7:0] val);
            case (idx)
                REG_DIRECTION:
                begin
                    regs.direction = val[0];
                    rearm();
                end
                REG_EXTENDED: regs.extended_set        = val[0];
                REG_END_CODE: regs.end_code            = val;
                REG_ESC_CODE: regs.escape_code         = val;
                REG_END_ESC:  regs.end_escaped_code    = val;
                REG_ESC_ESC:  regs.escape_escaped_code = val;
                REG_DC1_ESC:  regs.dc1_escaped_code    = val;
                REG_DC3_ESC:  regs.dc3_escaped_code    = val;
                default: ;
            endcase
        endfunction

        // works out the result beats of one accepted input beat
        function void take_input(bit cmd, logic [7:0] b);
            int         n;
            int         start_size;
            logic [7:0] v;
            bit         emit;
            result_t    r;
            n          = regs.extended_set ? 4 : 2;
            start_size = expected_q.size();
            v          = b;
            emit       = 1'b0;
            if (cmd)
            begin
                if (!regs.direction)
                begin
                    count_up();
                    add_beat(1'b1, regs.end_code, 1'b1, frame_bytes);
                end
                else
                    add_beat(1'b0, 8'h00, 1'b1, frame_bytes);
                rearm();
            end
            else if (!regs.direction)
            begin
                if (phase == PH_ENC_START)
                begin
                    frame_bytes = '0;
                    add_beat(1'b1, regs.end_code, 1'b0, 16'h0);
                    count_up();
                    phase = PH_NORMAL;
                end
                // first match wins when codes coincide
                for (int i = 0; i < n; i++)
                begin
                    if (v == raw_code(i))
                    begin
                        add_beat(1'b1, regs.escape_code, 1'b0, 16'h0);
                        count_up();
                        v = escaped_code(i);
                        break;
                    end
                end
                add_beat(1'b1, v, 1'b0, 16'h0);
                count_up();
            end
            else
            begin
                if (phase == PH_NORMAL)
                begin
                    if (v == regs.end_code)
                    begin
                        if (frame_bytes != 0)
                            phase = PH_DONE;
                    end
                    else if (v == regs.escape_code)
                        phase = PH_ESCAPE;
                    else
                        emit = 1'b1;
                end
                else if (phase == PH_ESCAPE)
                begin
                    // unknown escaped byte passes through, escape phase kept
                    for (int i = 0; i < n; i++)
                    begin
                        if (v == escaped_code(i))
                        begin
                            v     = raw_code(i);
                            phase = PH_NORMAL;
                            break;
                        end
                    end
                    emit = 1'b1;
                end
                else if (phase == PH_WAIT || phase == PH_ENC_START)
                begin
                    if (v == regs.end_code)
                    begin
                        phase       = PH_NORMAL;
                        frame_bytes = '0;
                    end
                end
                if (emit)
                begin
                    add_beat(1'b1, v, 1'b0, 16'h0);
                    count_up();
                end
            end
            if (expected_q.size() > start_size)
            begin
                r      = expected_q.pop_back();
                r.last = 1'b1;
                expected_q.push_back(r);
            end
        endfunction

        function void compare(string name, logic [15:0] want, logic [15:0] seen);
            if (want !== seen)
            begin
                $error("%s: expected %0h, got %0h", name, want, seen);
                failures++;
            end
        endfunction

        function void check_beat(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                $error("result beat with nothing expected, out_byte %0h", got.out_byte);
                failures++;
                return;
            end
            want = expected_q.pop_front();
            compare("byte_valid", want.byte_valid, got.byte_valid);
            compare("out_byte", want.out_byte, got.out_byte);
            compare("frame_done", want.frame_done, got.frame_done);
            compare("byte_count", want.byte_count, got.byte_count);
            compare("last", want.last, got.last);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_write = 1'b0;
    logic [2:0]  cfg_index = REG_DIRECTION;
    logic [7:0]  cfg_data  = 8'h00;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic        command   = 1'b0;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        byte_valid;
    logic [7:0]  out_byte;
    logic        frame_done;
    logic [15:0] byte_count;
    logic        last;

    codec_scoreboard board;
    int in_idle_pct  = 14;
    int out_idle_pct = 14;
    int beats_sent   = 0;
    int quiet_cycles = 0;

    slip_frame_codec dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .byte_valid (byte_valid),
        .out_byte   (out_byte),
        .frame_done (frame_done),
        .byte_count (byte_count),
        .last       (last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= out_idle_pct);

    // sample at the falling edge: what is seen here is accepted at the next rise
    always @(negedge clk)
    begin : watch_outputs
        result_t seen;
        if (rst_n)
        begin
            seen.byte_valid = byte_valid;
            seen.out_byte   = out_byte;
            seen.frame_done = frame_done;
            seen.byte_count = byte_count;
            seen.last       = last;
            if (out_valid && out_ready)
                board.check_beat(seen);
            if ((out_valid && out_ready) || (in_valid && in_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send_beat(bit cmd, logic [7:0] b);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        command   <= cmd;
        data_byte <= b;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
        board.take_input(cmd, b);
        beats_sent++;
    endtask

    task automatic send_end();
        send_beat(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // a beat with no result may still be inside the block once the queue is empty
    task automatic settle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        board.write_reg(idx, val);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_config(bit dir, bit ext, logic [7:0] endc, logic [7:0] escc,
                               logic [7:0] end_esc, logic [7:0] esc_esc,
                               logic [7:0] dc1_esc, logic [7:0] dc3_esc);
        write_reg(REG_EXTENDED, {7'h0, ext});
        write_reg(REG_END_CODE, endc);
        write_reg(REG_ESC_CODE, escc);
        write_reg(REG_END_ESC, end_esc);
        write_reg(REG_ESC_ESC, esc_esc);
        write_reg(REG_DC1_ESC, dc1_esc);
        write_reg(REG_DC3_ESC, dc3_esc);
        write_reg(REG_DIRECTION, {7'h0, dir});
    endtask

    // biased towards values that collide with each other
    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 11))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return DC1_BYTE;
            3:       return DC3_BYTE;
            4:       return 8'hC0;
            5:       return 8'hDB;
            6:       return 8'hDC;
            7:       return 8'hDD;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return board.regs.end_code;
        else if (r < 24)
            return board.regs.escape_code;
        else if (r < 30)
            return DC1_BYTE;
        else if (r < 36)
            return DC3_BYTE;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_escaped();
        case ($urandom_range(0, 4))
            0:       return board.regs.end_escaped_code;
            1:       return board.regs.escape_escaped_code;
            2:       return board.regs.dc1_escaped_code;
            3:       return board.regs.dc3_escaped_code;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic encode_frame();
        int len;
        len = $urandom_range(0, 8);
        repeat (len) send_beat(1'b0, pick_byte());
        if ($urandom_range(0, 19) == 0)
            hold_until_drained();
        if ($urandom_range(0, 99) < 85)
            send_end();
    endtask

    // mostly well-formed frames, with stray bytes and missing delimiters now and then
    task automatic decode_frame();
        int len;
        len = $urandom_range(0, 8);
        if ($urandom_range(0, 99) < 20)
            send_beat(1'b0, 8'($urandom_range(0, 255)));
        send_beat(1'b0, board.regs.end_code);
        repeat (len)
        begin
            if ($urandom_range(0, 99) < 25)
            begin
                send_beat(1'b0, board.regs.escape_code);
                send_beat(1'b0, pick_escaped());
            end
            else
                send_beat(1'b0, pick_byte());
        end
        if ($urandom_range(0, 19) == 0)
            hold_until_drained();
        if ($urandom_range(0, 99) < 80)
            send_beat(1'b0, board.regs.end_code);
        if ($urandom_range(0, 99) < 20)
            send_beat(1'b0, 8'($urandom_range(0, 255)));
        send_end();
    endtask

    initial
    begin
        int  base;
        int  phase_start;
        int  phase_no;
        bit  dir;
        bit  ext;
        logic [7:0] fill;
        board = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // encode with reset codes: end with no data, extremes, END, ESC, plain DC1/DC3
        send_end();
        send_beat(1'b0, 8'h00);
        send_beat(1'b0, 8'hFF);
        send_beat(1'b0, 8'hC0);
        send_beat(1'b0, 8'hDB);
        send_beat(1'b0, DC1_BYTE);
        send_beat(1'b0, DC3_BYTE);
        send_end();

        settle();
        write_reg(REG_EXTENDED, 8'h01);
        send_beat(1'b0, DC1_BYTE);
        send_beat(1'b0, DC3_BYTE);
        send_beat(1'b0, 8'hDC);
        send_end();

        // decode: stray byte, empty frame, every escape, unknown escape, trailing byte
        settle();
        write_reg(REG_DIRECTION, 8'h01);
        send_beat(1'b0, 8'h55);
        send_beat(1'b0, 8'hC0);
        send_beat(1'b0, 8'hC0);
        send_beat(1'b0, 8'h41);
        send_beat(1'b0, 8'hDB);
        send_beat(1'b0, 8'hDC);
        send_beat(1'b0, 8'hDB);
        send_beat(1'b0, 8'h77);
        send_beat(1'b0, 8'hDE);
        send_beat(1'b0, 8'hDB);
        send_beat(1'b0, 8'hDD);
        send_beat(1'b0, 8'hDB);
        send_beat(1'b0, 8'hDF);
        send_beat(1'b0, 8'hC0);
        send_beat(1'b0, 8'h99);
        send_end();

        // one long frame with no idling on either side
        settle();
        write_reg(REG_EXTENDED, 8'h00);
        write_reg(REG_DIRECTION, 8'h00);
        in_idle_pct  = 0;
        out_idle_pct = 0;
        repeat (BURST_ITEMS)
        begin
            fill = 8'($urandom_range(8'h20, 8'h7E));
            send_beat(1'b0, fill);
        end
        send_end();
        in_idle_pct  = 14;
        out_idle_pct = 14;

        base     = beats_sent;
        phase_no = 0;
        while (beats_sent - base < RANDOM_ITEMS)
        begin
            settle();
            if (phase_no < 4)
            begin
                dir = phase_no[0];
                ext = phase_no[1];
            end
            else
            begin
                dir = $urandom_range(0, 1);
                ext = $urandom_range(0, 1);
            end
            if (phase_no == 0)
                load_config(dir, ext, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
            else if (phase_no == 1)
                load_config(dir, ext, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
            else
                load_config(dir, ext, pick_code(), pick_code(), pick_code(),
                            pick_code(), pick_code(), pick_code());
            phase_start = beats_sent;
            while (beats_sent - phase_start < PHASE_ITEMS)
            begin
                if (dir)
                    decode_frame();
                else
                    encode_frame();
            end
            phase_no++;
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.failures == 0 && board.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
